// ===== rtl/core/bbog_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbog_pkg;

  localparam int SEG_W        = 5;
  localparam int CTRL_W       = 10;
  localparam int COORD_W      = 10;
  localparam int ANG_W        = 9;
  localparam int VTX_W        = 12;
  localparam int IDX_W        = 6;
  localparam int TRIG_W       = 17;
  localparam int TRIG_FRAC    = 15;
  localparam int MAX_SEGMENTS = 31;
  localparam int ANGLE_STEPS  = 360;
  localparam int QUARTER      = ANGLE_STEPS / 4;
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_CTRL1_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TIP_X   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SEG_CNT = 3'd5;

  localparam logic [CTRL_W-1:0] RST_CTRL1_X = 10'd40;
  localparam logic [CTRL_W-1:0] RST_CTRL1_Y = 10'd60;
  localparam logic [CTRL_W-1:0] RST_CTRL2_X = 10'd160;
  localparam logic [CTRL_W-1:0] RST_CTRL2_Y = 10'd90;
  localparam logic [CTRL_W-1:0] RST_TIP_X   = 10'd220;
  localparam logic [SEG_W-1:0]  RST_SEG_CNT = 5'd20;

  // quarter-wave sine, Q1.15, one entry per degree
  localparam logic [TRIG_W-1:0] QSIN [0:90] = '{
    17'd0,     17'd572,   17'd1144,  17'd1715,  17'd2286,  17'd2856,  17'd3425,
    17'd3993,  17'd4560,  17'd5126,  17'd5690,  17'd6252,  17'd6813,  17'd7371,
    17'd7927,  17'd8481,  17'd9032,  17'd9580,  17'd10126, 17'd10668, 17'd11207,
    17'd11743, 17'd12275, 17'd12803, 17'd13328, 17'd13848, 17'd14365, 17'd14876,
    17'd15384, 17'd15886, 17'd16384, 17'd16877, 17'd17364, 17'd17847, 17'd18324,
    17'd18795, 17'd19261, 17'd19720, 17'd20174, 17'd20622, 17'd21063, 17'd21498,
    17'd21926, 17'd22348, 17'd22763, 17'd23170, 17'd23571, 17'd23965, 17'd24351,
    17'd24730, 17'd25102, 17'd25466, 17'd25822, 17'd26170, 17'd26510, 17'd26842,
    17'd27166, 17'd27482, 17'd27789, 17'd28088, 17'd28378, 17'd28660, 17'd28932,
    17'd29197, 17'd29452, 17'd29698, 17'd29935, 17'd30163, 17'd30382, 17'd30592,
    17'd30792, 17'd30983, 17'd31164, 17'd31336, 17'd31499, 17'd31651, 17'd31795,
    17'd31928, 17'd32052, 17'd32166, 17'd32270, 17'd32365, 17'd32449, 17'd32524,
    17'd32588, 17'd32643, 17'd32688, 17'd32723, 17'd32748, 17'd32763, 17'd32768
  };

  typedef enum logic [4:0] {
    ST_UU   = 5'd0,
    ST_TT   = 5'd1,
    ST_U2U  = 5'd2,
    ST_T2T  = 5'd3,
    ST_U2T  = 5'd4,
    ST_T2U  = 5'd5,
    ST_W1X  = 5'd6,
    ST_W1Y  = 5'd7,
    ST_W2X  = 5'd8,
    ST_W2Y  = 5'd9,
    ST_TIP  = 5'd10,
    ST_YS   = 5'd11,
    ST_XC   = 5'd12,
    ST_XS   = 5'd13,
    ST_YC   = 5'd14,
    ST_RY   = 5'd15,
    ST_EMIT = 5'd16
  } step_t;

  typedef struct packed {
    logic signed [CTRL_W-1:0] c1x;
    logic signed [CTRL_W-1:0] c1y;
    logic signed [CTRL_W-1:0] c2x;
    logic signed [CTRL_W-1:0] c2y;
    logic signed [CTRL_W-1:0] tip;
    logic [SEG_W-1:0]         seg;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  run;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic item_last;
  } sts_t;

  function automatic logic [ANG_W-1:0] wrap_angle(input logic [ANG_W:0] a);
    logic [ANG_W:0] w;
    w = (a >= (ANG_W+1)'(ANGLE_STEPS)) ? a - (ANG_W+1)'(ANGLE_STEPS) : a;
    return w[ANG_W-1:0];
  endfunction

  // a must already be below ANGLE_STEPS
  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANG_W-1:0] a);
    logic [6:0] idx;
    logic       neg;
    if (a < ANG_W'(QUARTER)) begin
      idx = a[6:0];
      neg = 1'b0;
    end else if (a < ANG_W'(2 * QUARTER)) begin
      idx = 7'(ANG_W'(2 * QUARTER) - a);
      neg = 1'b0;
    end else if (a < ANG_W'(3 * QUARTER)) begin
      idx = 7'(a - ANG_W'(2 * QUARTER));
      neg = 1'b1;
    end else begin
      idx = 7'(ANG_W'(ANGLE_STEPS) - a);
      neg = 1'b1;
    end
    return neg ? -$signed(QSIN[idx]) : $signed(QSIN[idx]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbog_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbog_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [bbog_pkg::REG_IDX_W-1:0] wr_idx,
  input  wire logic [bbog_pkg::CTRL_W-1:0]    wr_data,
  output bbog_pkg::cfg_t                      cfg
);

  bbog_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c1x <= bbog_pkg::RST_CTRL1_X;
      cfg_r.c1y <= bbog_pkg::RST_CTRL1_Y;
      cfg_r.c2x <= bbog_pkg::RST_CTRL2_X;
      cfg_r.c2y <= bbog_pkg::RST_CTRL2_Y;
      cfg_r.tip <= bbog_pkg::RST_TIP_X;
      cfg_r.seg <= bbog_pkg::RST_SEG_CNT;
    end else if (wr_en) begin
      case (wr_idx)
        bbog_pkg::REG_CTRL1_X: cfg_r.c1x <= wr_data;
        bbog_pkg::REG_CTRL1_Y: cfg_r.c1y <= wr_data;
        bbog_pkg::REG_CTRL2_X: cfg_r.c2x <= wr_data;
        bbog_pkg::REG_CTRL2_Y: cfg_r.c2y <= wr_data;
        bbog_pkg::REG_TIP_X:   cfg_r.tip <= wr_data;
        bbog_pkg::REG_SEG_CNT: cfg_r.seg <= wr_data[bbog_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/bbog_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divide of 2^FRAC_BITS by den, one quotient bit per cycle
module bbog_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bbog_pkg::SEG_W-1:0] den,
  output logic                            done,
  output logic [FRAC_BITS:0]              quo,
  output logic [bbog_pkg::SEG_W-1:0]      rem
);

  localparam int WW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 2);
  localparam int SW = bbog_pkg::SEG_W;

  logic [CW-1:0] cnt_r;
  logic          act_r;
  logic          done_r;
  logic [WW-1:0] quo_r;
  logic [SW-1:0] part_r;
  logic [SW-1:0] den_r;

  logic [SW:0] sh;
  logic        ge;

  assign sh = {part_r, (cnt_r == CW'(WW))};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      act_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(WW);
    end else if (act_r) begin
      cnt_r  <= cnt_r - CW'(1);
      act_r  <= (cnt_r != CW'(1));
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part_r <= '0;
      quo_r  <= '0;
      den_r  <= den;
    end else if (act_r) begin
      part_r <= ge ? SW'(sh - {1'b0, den_r}) : sh[SW-1:0];
      quo_r  <= {quo_r[WW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = part_r;

endmodule

`default_nettype wire

// ===== rtl/core/bbog_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbog_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  bbog_pkg::sts_t      sts,
  output logic                busy,
  output bbog_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  bbog_pkg::step_t step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RUN;
          step_nxt  = bbog_pkg::ST_UU;
        end
      end
      S_RUN: begin
        if (step_r == bbog_pkg::ST_EMIT) begin
          step_nxt = bbog_pkg::ST_UU;
          if (sts.item_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          step_nxt = bbog_pkg::step_t'(step_r + 5'd1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= bbog_pkg::ST_UU;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign cmd.load = start && (state_r == S_IDLE);
  assign cmd.run  = (state_r == S_RUN);
  assign cmd.step = step_r;

endmodule

`default_nettype wire

// ===== rtl/core/bbog_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbog_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  bbog_pkg::cmd_t                      cmd,
  input  bbog_pkg::cfg_t                      cfg,
  input  wire logic [bbog_pkg::COORD_W-1:0]   center_x,
  input  wire logic [bbog_pkg::COORD_W-1:0]   center_y,
  input  wire logic [bbog_pkg::ANG_W-1:0]     angle_deg,
  output bbog_pkg::sts_t                      sts,
  output logic                                vld,
  output logic signed [bbog_pkg::VTX_W-1:0]   vertex_x,
  output logic signed [bbog_pkg::VTX_W-1:0]   vertex_y,
  output logic [bbog_pkg::IDX_W-1:0]          vertex_index,
  output logic                                last
);

  localparam int F   = FRAC_BITS;
  localparam int WW  = F + 1;
  localparam int AW  = F + 11;
  localparam int BW  = (F + 2 > bbog_pkg::TRIG_W) ? F + 2 : bbog_pkg::TRIG_W;
  localparam int PW  = AW + BW;
  localparam int SH  = F + bbog_pkg::TRIG_FRAC;
  localparam int SW  = bbog_pkg::SEG_W;
  localparam int CW  = bbog_pkg::CTRL_W;
  localparam int VW  = bbog_pkg::VTX_W;

  // item context
  logic [bbog_pkg::COORD_W-1:0]      cx_r, cy_r;
  logic signed [bbog_pkg::TRIG_W-1:0] s_r, c_r;
  logic [SW-1:0]                      n_r, k_r, acc_r;
  logic                               curve_r;
  logic [bbog_pkg::IDX_W-1:0]         idx_r;
  logic [WW-1:0]                      t_r;

  // per-point values
  logic [WW-1:0]        u2_r, t2_r, u3_r, t3_r, w1_r, w2_r;
  logic signed [AW-1:0] x_r, y_r;
  logic signed [PW-1:0] p_r, rx_r, ry_r;

  logic                 vld_r, last_r;
  logic [VW-1:0]        vx_r, vy_r;
  logic [bbog_pkg::IDX_W-1:0] vidx_r;

  // clamped segment count
  logic [SW-1:0] n_clamp;
  assign n_clamp = (cfg.seg == '0) ? SW'(1) :
                   (cfg.seg > SW'(bbog_pkg::MAX_SEGMENTS)) ? SW'(bbog_pkg::MAX_SEGMENTS) :
                   cfg.seg;

  logic [bbog_pkg::ANG_W-1:0] ang_s, ang_c;
  assign ang_s = bbog_pkg::wrap_angle({1'b0, angle_deg});
  assign ang_c = bbog_pkg::wrap_angle({1'b0, ang_s} + (bbog_pkg::ANG_W+1)'(bbog_pkg::QUARTER));

  logic          div_done;
  logic [WW-1:0] dq;
  logic [SW-1:0] dr;

  bbog_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load),
    .den   (n_clamp),
    .done  (div_done),
    .quo   (dq),
    .rem   (dr)
  );

  // weights and operands
  logic [WW-1:0] u;
  assign u = {1'b1, {F{1'b0}}} - t_r;

  logic signed [AW-1:0] u_a, t_a, u2_a, t2_a, w1_a, w2_a, tw_a;
  logic signed [BW-1:0] u_b, t_b, cxa_b, cya_b, cxb_b, cyb_b, tip_b, s_b, c_b;

  assign u_a  = {{(AW-WW){1'b0}}, u};
  assign t_a  = {{(AW-WW){1'b0}}, t_r};
  assign u2_a = {{(AW-WW){1'b0}}, u2_r};
  assign t2_a = {{(AW-WW){1'b0}}, t2_r};
  assign w1_a = {{(AW-WW){1'b0}}, w1_r};
  assign w2_a = {{(AW-WW){1'b0}}, w2_r};
  assign tw_a = {{(AW-WW){1'b0}}, (curve_r ? u3_r : t3_r)};

  assign u_b   = {{(BW-WW){1'b0}}, u};
  assign t_b   = {{(BW-WW){1'b0}}, t_r};
  assign cxa_b = curve_r ? {{(BW-CW){cfg.c2x[CW-1]}}, cfg.c2x}
                         : {{(BW-CW){cfg.c1x[CW-1]}}, cfg.c1x};
  assign cya_b = curve_r ? {{(BW-CW){cfg.c2y[CW-1]}}, cfg.c2y}
                         : {{(BW-CW){cfg.c1y[CW-1]}}, cfg.c1y};
  assign cxb_b = curve_r ? {{(BW-CW){cfg.c1x[CW-1]}}, cfg.c1x}
                         : {{(BW-CW){cfg.c2x[CW-1]}}, cfg.c2x};
  assign cyb_b = curve_r ? {{(BW-CW){cfg.c1y[CW-1]}}, cfg.c1y}
                         : {{(BW-CW){cfg.c2y[CW-1]}}, cfg.c2y};
  assign tip_b = {{(BW-CW){cfg.tip[CW-1]}}, cfg.tip};
  assign s_b   = {{(BW-bbog_pkg::TRIG_W){s_r[bbog_pkg::TRIG_W-1]}}, s_r};
  assign c_b   = {{(BW-bbog_pkg::TRIG_W){c_r[bbog_pkg::TRIG_W-1]}}, c_r};

  logic signed [AW-1:0] op_a;
  logic signed [BW-1:0] op_b;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.step)
      bbog_pkg::ST_UU:  begin op_a = u_a;  op_b = u_b;   end
      bbog_pkg::ST_TT:  begin op_a = t_a;  op_b = t_b;   end
      bbog_pkg::ST_U2U: begin op_a = u2_a; op_b = u_b;   end
      bbog_pkg::ST_T2T: begin op_a = t2_a; op_b = t_b;   end
      bbog_pkg::ST_U2T: begin op_a = u2_a; op_b = t_b;   end
      bbog_pkg::ST_T2U: begin op_a = t2_a; op_b = u_b;   end
      bbog_pkg::ST_W1X: begin op_a = w1_a; op_b = cxa_b; end
      bbog_pkg::ST_W1Y: begin op_a = w1_a; op_b = cya_b; end
      bbog_pkg::ST_W2X: begin op_a = w2_a; op_b = cxb_b; end
      bbog_pkg::ST_W2Y: begin op_a = w2_a; op_b = cyb_b; end
      bbog_pkg::ST_TIP: begin op_a = tw_a; op_b = tip_b; end
      bbog_pkg::ST_YS:  begin op_a = y_r;  op_b = s_b;   end
      bbog_pkg::ST_XC:  begin op_a = x_r;  op_b = c_b;   end
      bbog_pkg::ST_XS:  begin op_a = x_r;  op_b = s_b;   end
      bbog_pkg::ST_YC:  begin op_a = y_r;  op_b = c_b;   end
      default: ;
    endcase
  end

  // product of the previous step, taken apart here
  logic [WW-1:0]        p_sh;
  logic [2*F+2:0]       p3;
  logic signed [AW-1:0] p_lo;

  assign p_sh = p_r[F+WW-1:F];
  assign p3   = {1'b0, p_r[2*F+1:0]} + {p_r[2*F+1:0], 1'b0};
  assign p_lo = p_r[AW-1:0];

  // truncation toward zero
  logic signed [PW-1:0] rx_adj, ry_adj;
  assign rx_adj = rx_r + {{(PW-SH){1'b0}}, {SH{rx_r[PW-1]}}};
  assign ry_adj = ry_r + {{(PW-SH){1'b0}}, {SH{ry_r[PW-1]}}};

  // next t = t + 2^F/n with exact remainder carry
  logic [SW:0]   rsum;
  logic          carry;
  assign rsum  = {1'b0, acc_r} + {1'b0, dr};
  assign carry = rsum >= {1'b0, n_r};

  logic pt_end;
  assign pt_end = (k_r == n_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= center_x;
      cy_r    <= center_y;
      s_r     <= bbog_pkg::sin_deg(ang_s);
      c_r     <= bbog_pkg::sin_deg(ang_c);
      n_r     <= n_clamp;
      k_r     <= '0;
      acc_r   <= '0;
      t_r     <= '0;
      curve_r <= 1'b0;
      idx_r   <= '0;
    end else if (cmd.run) begin
      p_r <= op_a * op_b;
      case (cmd.step)
        bbog_pkg::ST_TT:   u2_r <= p_sh;
        bbog_pkg::ST_U2U:  t2_r <= p_sh;
        bbog_pkg::ST_T2T:  u3_r <= p_sh;
        bbog_pkg::ST_U2T:  t3_r <= p_sh;
        bbog_pkg::ST_T2U:  w1_r <= p3[F+WW-1:F];
        bbog_pkg::ST_W1X:  w2_r <= p3[F+WW-1:F];
        bbog_pkg::ST_W1Y:  x_r  <= p_lo;
        bbog_pkg::ST_W2X:  y_r  <= curve_r ? -p_lo : p_lo;
        bbog_pkg::ST_W2Y:  x_r  <= x_r + p_lo;
        bbog_pkg::ST_TIP:  y_r  <= curve_r ? y_r - p_lo : y_r + p_lo;
        bbog_pkg::ST_YS:   x_r  <= x_r + p_lo;
        bbog_pkg::ST_XC:   rx_r <= -p_r;
        bbog_pkg::ST_XS:   rx_r <= rx_r + p_r;
        bbog_pkg::ST_YC:   ry_r <= p_r;
        bbog_pkg::ST_RY:   ry_r <= ry_r + p_r;
        bbog_pkg::ST_EMIT: begin
          vx_r   <= {2'b00, cx_r} + rx_adj[SH+VW-1:SH];
          vy_r   <= {2'b00, cy_r} - ry_adj[SH+VW-1:SH];
          vidx_r <= idx_r;
          last_r <= curve_r && pt_end;
          idx_r  <= idx_r + 1'b1;
          if (pt_end) begin
            curve_r <= 1'b1;
            k_r     <= '0;
            acc_r   <= '0;
            t_r     <= '0;
          end else begin
            k_r   <= k_r + 1'b1;
            acc_r <= carry ? SW'(rsum - {1'b0, n_r}) : rsum[SW-1:0];
            t_r   <= t_r + dq + WW'(carry);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cmd.run && (cmd.step == bbog_pkg::ST_EMIT);
    end
  end

  assign sts.div_done  = div_done;
  assign sts.item_last = curve_r && pt_end;

  assign vld          = vld_r;
  assign vertex_x     = vx_r;
  assign vertex_y     = vy_r;
  assign vertex_index = vidx_r;
  assign last         = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/bezier_blade_outline_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Blade outline generator: cubic Bezier outline of one blade, rotated and placed.
// Input: pulse start with center and angle while busy is low; the item is taken
// at that edge and busy stays high until the last vertex has been issued.
// Output: one vertex per out_valid pulse (one cycle each), in order, out_last on
// the final one. The receiver cannot stall, so vertices are never held back.
// Config: cfg_valid/cfg_index/cfg_data, always ready; write only while idle.
// Sequence: a serial divide of 2^FRAC_BITS by the segment count runs first,
// then each vertex is worked out in steps on one shared multiplier
// (weights, curve point, rotation). One item is in work at a time.
// Reset: synchronous, active low; registers return to their default
// blade shape (40,60 / 160,90 / tip 220, 20 segments) and the block goes idle.
module bezier_blade_outline_generator #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bbog_pkg::COORD_W-1:0]      in_center_x,
  input  wire logic [bbog_pkg::COORD_W-1:0]      in_center_y,
  input  wire logic [bbog_pkg::ANG_W-1:0]        in_angle_deg,
  output logic                                   out_valid,
  output logic signed [bbog_pkg::VTX_W-1:0]      out_vertex_x,
  output logic signed [bbog_pkg::VTX_W-1:0]      out_vertex_y,
  output logic [bbog_pkg::IDX_W-1:0]             out_vertex_index,
  output logic                                   out_last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bbog_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [bbog_pkg::CTRL_W-1:0]       cfg_data
);

  bbog_pkg::cfg_t cfg;
  bbog_pkg::cmd_t cmd;
  bbog_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bbog_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  bbog_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  bbog_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg          (cfg),
    .center_x     (in_center_x),
    .center_y     (in_center_y),
    .angle_deg    (in_angle_deg),
    .sts          (sts),
    .vld          (out_valid),
    .vertex_x     (out_vertex_x),
    .vertex_y     (out_vertex_y),
    .vertex_index (out_vertex_index),
    .last         (out_last)
  );

`ifndef SYNTHESIS
  a_vld_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("vertex issued while idle");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("still busy after last vertex");

  a_mid_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("went idle before last vertex");

  a_vld_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("vertices back to back");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_bezier_blade_outline_generator.sv =====
`timescale 1ns / 1ps

module tb_bezier_blade_outline_generator;
  import bbog_pkg::*;

  localparam int FRAC = 16;
  localparam int ROT_SHIFT = FRAC + TRIG_FRAC;
  localparam int LIMIT_CYCLES = 2000000;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic [VTX_W-1:0] x;
    logic [VTX_W-1:0] y;
    logic [IDX_W-1:0] idx;
    logic             last;
  } vertex_t;

  class outline_board;
    vertex_t pending[$];
    int mismatches;
    int checked;
    logic signed [CTRL_W-1:0] c1x, c1y, c2x, c2y, tip;
    logic [SEG_W-1:0] seg;

    function new();
      mismatches = 0;
      checked = 0;
      c1x = RST_CTRL1_X;
      c1y = RST_CTRL1_Y;
      c2x = RST_CTRL2_X;
      c2y = RST_CTRL2_Y;
      tip = RST_TIP_X;
      seg = RST_SEG_CNT;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CTRL_W-1:0] data);
      case (idx)
        REG_CTRL1_X: c1x = data;
        REG_CTRL1_Y: c1y = data;
        REG_CTRL2_X: c2x = data;
        REG_CTRL2_Y: c2y = data;
        REG_TIP_X:   tip = data;
        REG_SEG_CNT: seg = data[SEG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sine_q15(int deg);
      int a;
      int r;
      a = deg % ANGLE_STEPS;
      r = a % QUARTER;
      case (a / QUARTER)
        0: return longint'(QSIN[r]);
        1: return longint'(QSIN[QUARTER - r]);
        2: return -longint'(QSIN[r]);
        default: return -longint'(QSIN[QUARTER - r]);
      endcase
    endfunction

    function longint trunc_rot(longint v);
      if (v < 0) return -((-v) >>> ROT_SHIFT);
      return v >>> ROT_SHIFT;
    endfunction

    // expected vertices of one blade outline
    function void note_item(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [ANG_W-1:0] ang);
      longint n, t, u, u2, u3, t2, t3, w1, w2, x, y, rx, ry, s, c;
      longint p1x, p1y, p2x, p2y, ptip;
      int total, idx;
      vertex_t v;
      n = (seg == 0) ? 1 : longint'(seg);
      if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
      total = 2 * int'(n + 1);
      s = sine_q15(int'(ang));
      c = sine_q15(int'(ang) + QUARTER);
      p1x = longint'(c1x);
      p1y = longint'(c1y);
      p2x = longint'(c2x);
      p2y = longint'(c2y);
      ptip = longint'(tip);
      idx = 0;
      for (int curve = 0; curve < 2; curve++) begin
        for (longint k = 0; k <= n; k++) begin
          t = (k << FRAC) / n;
          u = (longint'(1) << FRAC) - t;
          u2 = (u * u) >> FRAC;
          u3 = (u2 * u) >> FRAC;
          t2 = (t * t) >> FRAC;
          t3 = (t2 * t) >> FRAC;
          w1 = (3 * u2 * t) >> FRAC;
          w2 = (3 * t2 * u) >> FRAC;
          if (curve == 0) begin
            x = w1 * p1x + w2 * p2x + t3 * ptip;
            y = w1 * p1y + w2 * p2y;
          end else begin
            x = u3 * ptip + w1 * p2x + w2 * p1x;
            y = -(w1 * p2y + w2 * p1y);
          end
          rx = trunc_rot(x * c - y * s);
          ry = trunc_rot(x * s + y * c);
          v.x = VTX_W'(longint'(cx) + rx);
          v.y = VTX_W'(longint'(cy) - ry);
          v.idx = IDX_W'(idx);
          v.last = (idx == total - 1);
          pending.push_back(v);
          idx++;
        end
      end
    endfunction

    function void check_vertex(logic [VTX_W-1:0] x, logic [VTX_W-1:0] y,
                               logic [IDX_W-1:0] idx, logic last);
      vertex_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d idx=%0d last=%0b",
                 $time, $signed(x), $signed(y), idx, last);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (x !== e.x) begin
        $display("%0t: vertex_x expected %0d actual %0d (idx %0d)",
                 $time, $signed(e.x), $signed(x), e.idx);
        mismatches++;
      end
      if (y !== e.y) begin
        $display("%0t: vertex_y expected %0d actual %0d (idx %0d)",
                 $time, $signed(e.y), $signed(y), e.idx);
        mismatches++;
      end
      if (idx !== e.idx) begin
        $display("%0t: vertex_index expected %0d actual %0d", $time, e.idx, idx);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0b actual %0b (idx %0d)",
                 $time, e.last, last, e.idx);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [COORD_W-1:0] in_center_x = '0;
  logic [COORD_W-1:0] in_center_y = '0;
  logic [ANG_W-1:0] in_angle_deg = '0;
  logic out_valid;
  logic signed [VTX_W-1:0] out_vertex_x;
  logic signed [VTX_W-1:0] out_vertex_y;
  logic [IDX_W-1:0] out_vertex_index;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CTRL_W-1:0] cfg_data = '0;

  outline_board board;
  int idle_pct = 0;
  int items_sent = 0;
  int settings = 0;
  int cycles = 0;

  bezier_blade_outline_generator #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_angle_deg(in_angle_deg),
    .out_valid(out_valid),
    .out_vertex_x(out_vertex_x),
    .out_vertex_y(out_vertex_y),
    .out_vertex_index(out_vertex_index),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_bezier_blade_outline_generator failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_vertex(out_vertex_x, out_vertex_y, out_vertex_index, out_last);
  end

  task automatic send_blade(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [ANG_W-1:0] ang);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_center_x <= cx;
    in_center_y <= cy;
    in_angle_deg <= ang;
    do @(posedge clk); while (busy);
    board.note_item(cx, cy, ang);
    items_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0 || busy);
  endtask

  task automatic write_cfg(input logic [REG_IDX_W-1:0] idx, input logic [CTRL_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_shape(input logic [CTRL_W-1:0] p1x, input logic [CTRL_W-1:0] p1y,
                            input logic [CTRL_W-1:0] p2x, input logic [CTRL_W-1:0] p2y,
                            input logic [CTRL_W-1:0] ptip, input logic [CTRL_W-1:0] nseg);
    write_cfg(REG_CTRL1_X, p1x);
    write_cfg(REG_CTRL1_Y, p1y);
    write_cfg(REG_CTRL2_X, p2x);
    write_cfg(REG_CTRL2_Y, p2y);
    write_cfg(REG_TIP_X, ptip);
    write_cfg(REG_SEG_CNT, nseg);
    settings++;
  endtask

  task automatic send_random;
    send_blade(COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
               ANG_W'($urandom_range(511)));
  endtask

  initial begin
    logic [CTRL_W-1:0] nseg;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset shape: quadrant edges, wrapped angles, extreme centers
    settings++;
    send_blade(10'd0, 10'd0, 9'd0);
    send_blade(10'd1023, 10'd1023, 9'd90);
    send_blade(10'd512, 10'd511, 9'd180);
    send_blade(10'd0, 10'd1023, 9'd270);
    send_blade(10'd1023, 10'd0, 9'd359);
    send_blade(10'd300, 10'd300, 9'd360);
    send_blade(10'd700, 10'd200, 9'd511);
    send_blade(10'd341, 10'd682, 9'd45);
    drain();

    // extreme shape, zero segment count, writes to unused indexes
    load_shape(10'h200, 10'h1ff, 10'h1ff, 10'h200, 10'h200, 10'd0);
    write_cfg(REG_SPARE_6, 10'h3ff);
    write_cfg(REG_SPARE_7, 10'h155);
    send_blade(10'd0, 10'd0, 9'd0);
    send_blade(10'd1023, 10'd1023, 9'd135);
    send_blade(10'd512, 10'd512, 9'd450);
    send_blade(10'd100, 10'd900, 9'd225);
    drain();

    load_shape(10'h1ff, 10'h1ff, 10'h1ff, 10'h1ff, 10'h1ff, 10'd31);
    send_blade(10'd1023, 10'd0, 9'd315);
    send_blade(10'd0, 10'd1023, 9'd1);
    drain();

    load_shape(10'h200, 10'h200, 10'h200, 10'h200, 10'h1ff, 10'd1);
    send_blade(10'd512, 10'd512, 9'd89);
    send_blade(10'd512, 10'd512, 9'd91);
    drain();

    for (int grp = 0; grp < 20; grp++) begin
      case (grp % 4)
        0: idle_pct = 0;
        1: idle_pct = 74;
        2: idle_pct = 35;
        default: idle_pct = 0;
      endcase
      if ($urandom_range(5) == 0) nseg = CTRL_W'($urandom_range(1023));
      else nseg = CTRL_W'($urandom_range(9));
      load_shape(CTRL_W'($urandom_range(1023)), CTRL_W'($urandom_range(1023)),
                 CTRL_W'($urandom_range(1023)), CTRL_W'($urandom_range(1023)),
                 CTRL_W'($urandom_range(1023)), nseg);
      repeat (14) send_random();
      drain();
    end
    idle_pct = 0;

    repeat (40) @(posedge clk);
    $display("covered %0d blade items, %0d vertices checked, %0d register settings",
             items_sent, board.checked, settings);
    $display("angles up to 511 deg, segment counts 0..31, control points at both limits");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb_bezier_blade_outline_generator passed");
    end else begin
      $display("%0d mismatches, %0d vertices missing", board.mismatches,
               board.pending.size());
      $display("tb_bezier_blade_outline_generator failed");
    end
    $finish;
  end

endmodule
